// ----- rtl/bffa_pkg.sv -----
// shared types, constants and helpers for the bitmap first-free allocator
// no dependencies
`timescale 1ns / 1ps

package bffa_pkg;

  localparam int DEF_NUM_ENTRIES = 1024;
  localparam int WORD_W          = 32;
  localparam int BIT_W           = 5;
  localparam int NUM_W           = 11;
  localparam int STATUS_W        = 2;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  localparam logic [NUM_W-1:0] ENTRIES_RESET = 11'd1024;
  localparam logic             REG_ENTRIES   = 1'b0;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK           = 2'd0,
    STATUS_NONE_FREE    = 2'd1,
    STATUS_OUT_OF_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_REL,
    S_RESP
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic alloc_start;
    logic scan_step;
    logic rel_read;
    logic rel_reject;
    logic rel_apply;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic rel_bad;
    logic hit;
    logic exhausted;
  } sts_t;

  // lowest zero bit of a bitmap word
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] word);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!word[b]) begin
        idx = BIT_W'(b);
      end
    end
    return idx;
  endfunction

endpackage

// ----- rtl/bffa_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module bffa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/bffa_dp.sv -----
// datapath: bitmap ram, word scan, release update, allocated count and result registers
// depends on bffa_pkg and bffa_ram
`timescale 1ns / 1ps

module bffa_dp #(
  parameter int NUM_ENTRIES = bffa_pkg::DEF_NUM_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bffa_pkg::cmd_t                cmd,
  output bffa_pkg::sts_t                sts,
  input  logic [bffa_pkg::NUM_W-1:0]    entries,
  input  logic [bffa_pkg::NUM_W-1:0]    release_number,
  output logic [bffa_pkg::NUM_W-1:0]    granted_number,
  output logic [bffa_pkg::STATUS_W-1:0] status,
  output logic [bffa_pkg::NUM_W-1:0]    free_count
);

  localparam int WORD_W    = bffa_pkg::WORD_W;
  localparam int BIT_W     = bffa_pkg::BIT_W;
  localparam int NUM_W     = bffa_pkg::NUM_W;
  localparam int NUM_WORDS = (NUM_ENTRIES + WORD_W - 1) / WORD_W;
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int WCNT_W    = $clog2(NUM_WORDS + 1);
  localparam int NW_W      = NUM_W - BIT_W + 1;

  logic [NUM_W-1:0]   lim;
  logic [NW_W-1:0]    nw;
  logic [NUM_W:0]     lim_round;

  logic [WADDR_W-1:0] clr_ptr_r;
  logic [WCNT_W-1:0]  rd_ptr_r;
  logic [WADDR_W-1:0] chk_ptr_r;
  logic               dv_r;
  logic [WADDR_W-1:0] rel_word_r;
  logic [BIT_W-1:0]   rel_bit_r;
  logic [NUM_W-1:0]   count_r;
  logic [NUM_W-1:0]   granted_r;
  bffa_pkg::status_t  status_r;

  logic               ram_we;
  logic [WADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [WADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  logic               iss;
  logic [WORD_W-1:0]  tail_mask;
  logic [WORD_W-1:0]  word_eff;
  logic [BIT_W-1:0]   zbit;
  logic [31:0]        rel_idx;
  logic [31:0]        grant_num;

  bffa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS),
    .AW    (WADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // effective limit saturated at capacity
  assign lim = (32'(entries) > 32'(NUM_ENTRIES)) ? NUM_W'(NUM_ENTRIES) : entries;
  assign lim_round = {1'b0, lim} + (NUM_W + 1)'(WORD_W - 1);
  assign nw = NW_W'(lim_round >> BIT_W);

  assign iss = 32'(rd_ptr_r) < 32'(nw);

  always_comb begin
    tail_mask = '0;
    if ((32'(chk_ptr_r) == 32'(nw) - 32'd1) && (lim[BIT_W-1:0] != '0)) begin
      tail_mask = ~((WORD_W'(1) << lim[BIT_W-1:0]) - WORD_W'(1));
    end
  end

  assign word_eff  = ram_rdata | tail_mask;
  assign zbit      = bffa_pkg::first_zero(word_eff);
  assign rel_idx   = 32'(release_number) - 32'd1;
  assign grant_num = (32'(chk_ptr_r) << BIT_W) + 32'(zbit) + 32'd1;

  assign sts.clear_done = clr_ptr_r == WADDR_W'(NUM_WORDS - 1);
  assign sts.rel_bad    = (release_number == '0) || (release_number > lim);
  assign sts.hit        = dv_r && (word_eff != '1);
  assign sts.exhausted  = !dv_r && !iss;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = rd_ptr_r[WADDR_W-1:0];
    if (cmd.scan_step) begin
      ram_re = iss;
    end else if (cmd.rel_read) begin
      ram_re    = 1'b1;
      ram_raddr = WADDR_W'(rel_idx >> BIT_W);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_ptr_r;
    ram_wdata = '0;
    priority if (cmd.clear_step) begin
      ram_we = 1'b1;
    end else if (cmd.scan_step && sts.hit) begin
      ram_we    = 1'b1;
      ram_waddr = chk_ptr_r;
      ram_wdata = ram_rdata | (WORD_W'(1) << zbit);
    end else if (cmd.rel_apply && ram_rdata[rel_bit_r]) begin
      ram_we    = 1'b1;
      ram_waddr = rel_word_r;
      ram_wdata = ram_rdata & ~(WORD_W'(1) << rel_bit_r);
    end else begin
      ram_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r <= '0;
      rd_ptr_r  <= '0;
      dv_r      <= 1'b0;
      count_r   <= '0;
    end else begin
      if (cmd.clear_step && !sts.clear_done) begin
        clr_ptr_r <= clr_ptr_r + WADDR_W'(1);
      end
      if (cmd.alloc_start) begin
        rd_ptr_r <= '0;
        dv_r     <= 1'b0;
      end else if (cmd.scan_step) begin
        if (iss) begin
          rd_ptr_r <= rd_ptr_r + WCNT_W'(1);
        end
        dv_r <= iss;
      end
      if (cmd.scan_step && sts.hit) begin
        count_r <= count_r + NUM_W'(1);
      end else if (cmd.rel_apply && ram_rdata[rel_bit_r] && (count_r != '0)) begin
        count_r <= count_r - NUM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      chk_ptr_r <= rd_ptr_r[WADDR_W-1:0];
    end
    if (cmd.rel_read) begin
      rel_word_r <= WADDR_W'(rel_idx >> BIT_W);
      rel_bit_r  <= rel_idx[BIT_W-1:0];
    end
    if (cmd.scan_step && sts.hit) begin
      granted_r <= grant_num[NUM_W-1:0];
      status_r  <= bffa_pkg::STATUS_OK;
    end else if (cmd.scan_step && sts.exhausted) begin
      granted_r <= '0;
      status_r  <= bffa_pkg::STATUS_NONE_FREE;
    end else if (cmd.rel_reject) begin
      granted_r <= '0;
      status_r  <= bffa_pkg::STATUS_OUT_OF_RANGE;
    end else if (cmd.rel_apply) begin
      granted_r <= '0;
      status_r  <= bffa_pkg::STATUS_OK;
    end
  end

  assign granted_number = granted_r;
  assign status         = status_r;
  assign free_count     = (count_r >= lim) ? '0 : lim - count_r;

endmodule

// ----- rtl/bffa_ctrl.sv -----
// controller state machine: clearing pass, request dispatch, scan and result strobe
// depends on bffa_pkg
`timescale 1ns / 1ps

module bffa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           kind,
  input  bffa_pkg::sts_t sts,
  output bffa_pkg::cmd_t cmd,
  output logic           busy,
  output logic           out_valid
);

  bffa_pkg::state_t state_r;
  bffa_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bffa_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      bffa_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_nxt = bffa_pkg::S_IDLE;
        end
      end
      bffa_pkg::S_IDLE: begin
        if (start) begin
          if (kind == bffa_pkg::KIND_ALLOC) begin
            cmd.alloc_start = 1'b1;
            state_nxt       = bffa_pkg::S_SCAN;
          end else if (sts.rel_bad) begin
            cmd.rel_reject = 1'b1;
            state_nxt      = bffa_pkg::S_RESP;
          end else begin
            cmd.rel_read = 1'b1;
            state_nxt    = bffa_pkg::S_REL;
          end
        end
      end
      bffa_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit || sts.exhausted) begin
          state_nxt = bffa_pkg::S_RESP;
        end
      end
      bffa_pkg::S_REL: begin
        cmd.rel_apply = 1'b1;
        state_nxt     = bffa_pkg::S_RESP;
      end
      bffa_pkg::S_RESP: begin
        state_nxt = bffa_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bffa_pkg::S_IDLE;
      end
    endcase
  end

  assign busy      = state_r != bffa_pkg::S_IDLE;
  assign out_valid = state_r == bffa_pkg::S_RESP;

endmodule

// ----- rtl/bitmap_first_free_allocator_unit.sv -----
// Bitmap first-free allocator. A transaction is taken when start is high and busy is low;
// its result appears for one cycle with out_valid, and the receiver cannot stall it.
// An allocate reads the bitmap ram one 32-entry word per cycle and checks each word in the
// cycle after its read; the scan stops at the first word with a free entry, or after the
// last word within the limit when none is free, and the strobe follows in the result state.
// With a limit of zero no word is read and the allocate reports none free. A release goes
// through the release state, which updates the word read at acceptance, to the result state;
// a rejected one goes straight to the result state; busy stays high through the strobe cycle
// and falls as it ends. After reset a clearing pass writes one word per cycle through every
// bitmap word with busy high; the register port works throughout.
// depends on bffa_pkg, bffa_ctrl, bffa_dp, bffa_ram
`timescale 1ns / 1ps

module bitmap_first_free_allocator_unit #(
  parameter int NUM_ENTRIES = bffa_pkg::DEF_NUM_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic [bffa_pkg::NUM_W-1:0]    in_release_number,
  output logic                          out_valid,
  output logic [bffa_pkg::NUM_W-1:0]    out_granted_number,
  output logic [bffa_pkg::STATUS_W-1:0] out_status,
  output logic [bffa_pkg::NUM_W-1:0]    out_free_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bffa_pkg::PADDR_W-1:0]  paddr,
  input  logic [bffa_pkg::PDATA_W-1:0]  pwdata,
  output logic [bffa_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic [bffa_pkg::NUM_W-1:0] entries_r;
  bffa_pkg::cmd_t             cmd;
  bffa_pkg::sts_t             sts;
  logic                       cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = paddr[bffa_pkg::PADDR_W-1] == bffa_pkg::REG_ENTRIES;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= bffa_pkg::ENTRIES_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      entries_r <= pwdata[bffa_pkg::NUM_W-1:0];
    end
  end

  assign prdata = cfg_hit ? bffa_pkg::PDATA_W'(entries_r) : '0;

  bffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .kind      (in_kind),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  bffa_dp #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .entries        (entries_r),
    .release_number (in_release_number),
    .granted_number (out_granted_number),
    .status         (out_status),
    .free_count     (out_free_count)
  );

endmodule
